### design/vct_pkg.sv
// ----------------------------------------------------------------------------
// vct_pkg
// Types, widths and register codes shared by the view cone test block.
// ----------------------------------------------------------------------------
package vct_pkg;

  localparam int COORD_BITS  = 16;
  localparam int FACING_BITS = 16;
  localparam int CFG_BITS    = 16;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  // t = target - self, and its square (magnitude fits in COORD_BITS)
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int LEN_W  = SQ_W + 2;

  // facing . t
  localparam int PROD_W = FACING_BITS + DIFF_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int DMAG_W = DOT_W - 1;
  localparam int DLO_W  = DMAG_W / 2;
  localparam int DHI_W  = DMAG_W - DLO_W;
  localparam int D2_W   = 2 * DMAG_W;

  // cos^2 * L
  localparam int C2_W  = 2 * CFG_BITS - 1;
  localparam int LLO_W = LEN_W / 2;
  localparam int LHI_W = LEN_W - LLO_W;
  localparam int RHS_W = C2_W + LEN_W;

  localparam int CMP_W = (D2_W > RHS_W) ? D2_W : RHS_W;
  localparam int LIM_W = 2 * CFG_BITS;

  typedef enum logic {
    REG_COS_HALF_ANGLE = 1'b0,
    REG_MAX_DISTANCE   = 1'b1
  } vct_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  self_x;
    logic signed [COORD_BITS-1:0]  self_y;
    logic signed [COORD_BITS-1:0]  self_z;
    logic signed [FACING_BITS-1:0] facing_x;
    logic signed [FACING_BITS-1:0] facing_y;
    logic signed [FACING_BITS-1:0] facing_z;
    logic signed [COORD_BITS-1:0]  target_x;
    logic signed [COORD_BITS-1:0]  target_y;
    logic signed [COORD_BITS-1:0]  target_z;
  } vct_item_t;

  typedef struct packed {
    logic in_view;
    logic within_angle;
    logic within_range;
  } vct_result_t;

  // derived config values, held in registers
  typedef struct packed {
    logic              c_neg;
    logic [C2_W-1:0]   c2;
    logic [LIM_W-1:0]  lim;
  } vct_cfg_t;

  // per-lane products
  typedef struct packed {
    logic [2:0][SQ_W-1:0]   sq;
    logic [2:0][PROD_W-1:0] dp;
  } vct_prod_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [DOT_W-1:0] dot;
  } vct_sum_t;

endpackage

### design/vct_cfg.sv
// ----------------------------------------------------------------------------
// vct_cfg
// APB register file: cosine of half angle and sight range, plus the
// registered squares used by the datapath.
// ----------------------------------------------------------------------------
module vct_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vct_pkg::PADDR_W-1:0]    paddr,
  input  logic [vct_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vct_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output vct_pkg::vct_cfg_t              cfg
);
  import vct_pkg::*;

  logic [CFG_BITS-1:0] cos_half_angle;
  logic [CFG_BITS-1:0] max_distance;
  logic [CFG_BITS-1:0] cos_mag;
  vct_reg_t            reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = vct_reg_t'(paddr[2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_half_angle <= CFG_BITS'(23170);
      max_distance   <= CFG_BITS'(1000);
    end else if (wr_en) begin
      case (reg_idx)
        REG_COS_HALF_ANGLE: cos_half_angle <= pwdata[CFG_BITS-1:0];
        REG_MAX_DISTANCE:   max_distance   <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COS_HALF_ANGLE: prdata = APB_DATA_W'(cos_half_angle);
      REG_MAX_DISTANCE:   prdata = APB_DATA_W'(max_distance);
      default:            prdata = '0;
    endcase
  end

  // magnitude of -32768 is 32768, still fits unsigned
  assign cos_mag = cos_half_angle[CFG_BITS-1] ? (~cos_half_angle + 1'b1) : cos_half_angle;

  always_ff @(posedge clk) begin
    cfg.c_neg <= cos_half_angle[CFG_BITS-1];
    cfg.c2    <= C2_W'(cos_mag) * C2_W'(cos_mag);
    cfg.lim   <= LIM_W'(max_distance) * LIM_W'(max_distance);
  end

endmodule

### design/vct_prod.sv
// ----------------------------------------------------------------------------
// vct_prod
// Stages 1-2: difference vector, then per-lane squares and dot products.
// ----------------------------------------------------------------------------
module vct_prod (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  vct_pkg::vct_item_t item,
  output logic               out_valid,
  output vct_pkg::vct_prod_t prod
);
  import vct_pkg::*;

  logic signed [DIFF_W-1:0]      t_in [3];
  logic signed [FACING_BITS-1:0] f_in [3];
  logic signed [DIFF_W-1:0]      t1 [3];
  logic signed [FACING_BITS-1:0] f1 [3];
  logic                          v1;
  logic signed [2*DIFF_W-1:0]    sq_full [3];
  logic signed [PROD_W-1:0]      dp_full [3];

  always_comb begin
    t_in[0] = DIFF_W'(item.target_x) - DIFF_W'(item.self_x);
    t_in[1] = DIFF_W'(item.target_y) - DIFF_W'(item.self_y);
    t_in[2] = DIFF_W'(item.target_z) - DIFF_W'(item.self_z);
    f_in[0] = item.facing_x;
    f_in[1] = item.facing_y;
    f_in[2] = item.facing_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t1[i] <= t_in[i];
      f1[i] <= f_in[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = (2*DIFF_W)'(t1[i]) * (2*DIFF_W)'(t1[i]);
      dp_full[i] = PROD_W'(f1[i]) * PROD_W'(t1[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod.sq[i] <= sq_full[i][SQ_W-1:0];
      prod.dp[i] <= dp_full[i];
    end
  end

endmodule

### design/vct_sum.sv
// ----------------------------------------------------------------------------
// vct_sum
// Stage 3: squared length L and dot product D.
// ----------------------------------------------------------------------------
module vct_sum (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  vct_pkg::vct_prod_t prod,
  output logic               out_valid,
  output vct_pkg::vct_sum_t  sum
);
  import vct_pkg::*;

  logic [LEN_W-1:0]        len_next;
  logic signed [DOT_W-1:0] dot_next;

  always_comb begin
    len_next = LEN_W'(prod.sq[0]) + LEN_W'(prod.sq[1]) + LEN_W'(prod.sq[2]);
    dot_next = DOT_W'($signed(prod.dp[0])) + DOT_W'($signed(prod.dp[1]))
             + DOT_W'($signed(prod.dp[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sum.len <= len_next;
    sum.dot <= dot_next;
  end

endmodule

### design/vct_decide.sv
// ----------------------------------------------------------------------------
// vct_decide
// Stages 4-6: split products for D^2 and C^2*L and the range compare,
// then recombine, then the sign-aware cone decision.
// ----------------------------------------------------------------------------
module vct_decide (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  vct_pkg::vct_sum_t    sum,
  input  vct_pkg::vct_cfg_t    cfg,
  output logic                 out_valid,
  output vct_pkg::vct_result_t result
);
  import vct_pkg::*;

  logic                    d_neg;
  logic [DOT_W-1:0]        dot_abs;
  logic [DMAG_W-1:0]       dm;

  // stage 4
  logic                    v4;
  logic                    d_neg4;
  logic                    zero4;
  logic                    range4;
  logic [DLO_W+DMAG_W-1:0] pp_lo;
  logic [DHI_W+DMAG_W-1:0] pp_hi;
  logic [LLO_W+C2_W-1:0]   r_lo;
  logic [LHI_W+C2_W-1:0]   r_hi;

  // stage 5
  logic                    v5;
  logic                    d_neg5;
  logic                    zero5;
  logic                    range5;
  logic [D2_W-1:0]         d2;
  logic [RHS_W-1:0]        rhs;

  logic [CMP_W-1:0]        d2_c;
  logic [CMP_W-1:0]        rhs_c;
  logic                    angle;

  assign d_neg   = sum.dot[DOT_W-1];
  assign dot_abs = d_neg ? (~sum.dot + 1'b1) : sum.dot;
  assign dm      = dot_abs[DMAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v4        <= in_valid;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    d_neg4 <= d_neg;
    zero4  <= (sum.len == '0);
    range4 <= ({{LIM_W{1'b0}}, sum.len} < {{LEN_W{1'b0}}, cfg.lim});
    pp_lo  <= (DLO_W+DMAG_W)'(dm[DLO_W-1:0]) * (DLO_W+DMAG_W)'(dm);
    pp_hi  <= (DHI_W+DMAG_W)'(dm[DMAG_W-1:DLO_W]) * (DHI_W+DMAG_W)'(dm);
    r_lo   <= (LLO_W+C2_W)'(sum.len[LLO_W-1:0]) * (LLO_W+C2_W)'(cfg.c2);
    r_hi   <= (LHI_W+C2_W)'(sum.len[LEN_W-1:LLO_W]) * (LHI_W+C2_W)'(cfg.c2);
  end

  always_ff @(posedge clk) begin
    d_neg5 <= d_neg4;
    zero5  <= zero4;
    range5 <= range4;
    d2     <= D2_W'(pp_lo) + (D2_W'(pp_hi) << DLO_W);
    rhs    <= RHS_W'(r_lo) + (RHS_W'(r_hi) << LLO_W);
  end

  assign d2_c  = CMP_W'(d2);
  assign rhs_c = CMP_W'(rhs);

  // D > C*sqrt(L): signs first, squares only when both sides agree in sign
  always_comb begin
    if (zero5) begin
      angle = cfg.c_neg;
    end else if (!d_neg5 && cfg.c_neg) begin
      angle = 1'b1;
    end else if (d_neg5 && !cfg.c_neg) begin
      angle = 1'b0;
    end else if (d_neg5) begin
      angle = d2_c < rhs_c;
    end else begin
      angle = rhs_c < d2_c;
    end
  end

  always_ff @(posedge clk) begin
    result.in_view      <= angle & range5;
    result.within_angle <= angle;
    result.within_range <= range5;
  end

endmodule

### design/view_cone_test.sv
// ----------------------------------------------------------------------------
// view_cone_test
// Range and sight-cone test of a target against an observer.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock, busy never goes high. A result shows
// on result with done high for one cycle, once the item has passed through
// the pipeline (two product stages, one sum stage, three stages for the split
// D^2 / C^2*L products, recombination and compare). The receiver has no
// hold-off, so it must take every result in the cycle it appears. Register
// writes reach the datapath through the registered squares in vct_cfg and
// should be made with no items in flight.
module view_cone_test (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  vct_pkg::vct_item_t             item,
  output logic                           done,
  output vct_pkg::vct_result_t           result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vct_pkg::PADDR_W-1:0]    paddr,
  input  logic [vct_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vct_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import vct_pkg::*;

  vct_cfg_t  cfg;
  vct_prod_t prod;
  vct_sum_t  sum;
  logic      prod_valid;
  logic      sum_valid;
  logic      in_valid;

  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  vct_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vct_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .item      (item),
    .out_valid (prod_valid),
    .prod      (prod)
  );

  vct_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .prod      (prod),
    .out_valid (sum_valid),
    .sum       (sum)
  );

  vct_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .sum       (sum),
    .cfg       (cfg),
    .out_valid (done),
    .result    (result)
  );

endmodule

### tb/view_cone_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// view_cone_test_tb
// Self-checking bench for the view cone range and sight-angle test.
// ----------------------------------------------------------------------------
// Items go in over a start/busy command port from a queue of pending
// observer/target pairs. Each accepted item gets its expected result from a
// bit-exact software copy of the range and cone tests. Results are checked
// field by field in order. Both registers are rewritten over the APB port
// between phases, with the block drained first, to cover the extreme settings.
module view_cone_test_tb;
  import vct_pkg::*;

  localparam int NUM_PHASES       = 7;
  localparam int RANDOM_PER_PHASE = 240;
  localparam int DRAIN_CYCLES     = 12;   // pipeline is six deep
  localparam int STALL_LIMIT      = 1000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  vct_item_t             item = '0;
  logic                  done;
  vct_result_t           result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // register copies used for prediction
  logic signed [15:0] cos_mirror = 16'sd23170;
  logic [15:0]        range_mirror = 16'd1000;

  vct_item_t   sighting_q[$];
  vct_result_t visibility_q[$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;

  view_cone_test uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  function automatic vct_result_t predict_visibility(vct_item_t it,
                                                     logic signed [15:0] cos_v,
                                                     logic [15:0] range_v);
    longint      tx, ty, tz, dot, len, c;
    logic [127:0] dmag, d2, rhs;
    vct_result_t r;
    tx  = longint'($signed(it.target_x)) - longint'($signed(it.self_x));
    ty  = longint'($signed(it.target_y)) - longint'($signed(it.self_y));
    tz  = longint'($signed(it.target_z)) - longint'($signed(it.self_z));
    len = tx * tx + ty * ty + tz * tz;
    dot = longint'($signed(it.facing_x)) * tx + longint'($signed(it.facing_y)) * ty
        + longint'($signed(it.facing_z)) * tz;
    c   = longint'(cos_v);
    // cone test without sqrt: D > C*|t| decided by signs, then D^2 vs C^2*L
    if (len == 0) begin
      r.within_angle = (c < 0);
    end else if (dot >= 0 && c < 0) begin
      r.within_angle = 1'b1;
    end else if (dot < 0 && c >= 0) begin
      r.within_angle = 1'b0;
    end else begin
      dmag = 128'(dot < 0 ? -dot : dot);
      d2   = dmag * dmag;
      rhs  = 128'(c * c) * 128'(len);
      r.within_angle = (dot >= 0) ? (rhs < d2) : (d2 < rhs);
    end
    r.within_range = (len < longint'(range_v) * longint'(range_v));
    r.in_view      = r.within_angle & r.within_range;
    return r;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic vct_item_t place(int sx, int sy, int sz, int fx, int fy, int fz,
                                      int tx, int ty, int tz);
    vct_item_t it;
    it.self_x   = 16'(sx);
    it.self_y   = 16'(sy);
    it.self_z   = 16'(sz);
    it.facing_x = 16'(fx);
    it.facing_y = 16'(fy);
    it.facing_z = 16'(fz);
    it.target_x = 16'(tx);
    it.target_y = 16'(ty);
    it.target_z = 16'(tz);
    return it;
  endfunction

  // Mostly a nearby target with a facing aimed roughly at it; some pure noise.
  function automatic vct_item_t random_item(longint reach);
    logic [143:0] raw;
    vct_item_t    it;
    int unsigned  kind;
    longint       span;
    real          dx, dy, dz, tlen, spread, vx, vy, vz, vm;
    for (int k = 0; k < 144; k += 16) raw[k +: 16] = 16'($urandom);
    it   = raw;
    kind = $urandom_range(0, 9);
    if (kind <= 1) return it;
    span = (kind == 2) ? 4 : reach;
    it.self_x   = clip16(longint'($urandom_range(0, 60000)) - 30000);
    it.self_y   = clip16(longint'($urandom_range(0, 60000)) - 30000);
    it.self_z   = clip16(longint'($urandom_range(0, 60000)) - 30000);
    it.target_x = clip16(longint'($signed(it.self_x)) + longint'($urandom_range(0, 2 * span)) - span);
    it.target_y = clip16(longint'($signed(it.self_y)) + longint'($urandom_range(0, 2 * span)) - span);
    it.target_z = clip16(longint'($signed(it.self_z)) + longint'($urandom_range(0, 2 * span)) - span);
    if (kind == 3) return it;
    dx   = real'(longint'($signed(it.target_x)) - longint'($signed(it.self_x)));
    dy   = real'(longint'($signed(it.target_y)) - longint'($signed(it.self_y)));
    dz   = real'(longint'($signed(it.target_z)) - longint'($signed(it.self_z)));
    tlen = $sqrt(dx * dx + dy * dy + dz * dz);
    if (tlen == 0.0) return it;
    spread = real'($urandom_range(0, 1500)) / 1000.0;
    vx = dx / tlen + spread * (real'($urandom_range(0, 2000)) / 1000.0 - 1.0);
    vy = dy / tlen + spread * (real'($urandom_range(0, 2000)) / 1000.0 - 1.0);
    vz = dz / tlen + spread * (real'($urandom_range(0, 2000)) / 1000.0 - 1.0);
    vm = $sqrt(vx * vx + vy * vy + vz * vz);
    if (vm > 0.0) begin
      it.facing_x = clip16(longint'($rtoi(vx / vm * 32767.0)));
      it.facing_y = clip16(longint'($rtoi(vy / vm * 32767.0)));
      it.facing_z = clip16(longint'($rtoi(vz / vm * 32767.0)));
    end
    return it;
  endfunction

  // target at observer, range boundary, and exact cone boundary for current setup
  task automatic push_edge_cases();
    int d, c;
    d = int'(range_mirror);
    c = int'(cos_mirror);
    sighting_q.push_back(place(1234, -5, 77, 100, 200, 300, 1234, -5, 77));
    sighting_q.push_back(place(-32768, 0, 0, 32767, 0, 0, -32768 + d, 0, 0));
    if (d > 0) sighting_q.push_back(place(-32768, 0, 0, 32767, 0, 0, -32769 + d, 0, 0));
    sighting_q.push_back(place(-32768, 0, 0, c, 0, 0,
                               -32768 + int'($urandom_range(1, 40000)), 0, 0));
  endtask

  task automatic write_register(vct_reg_t idx, logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_COS_HALF_ANGLE) cos_mirror = value;
    else range_mirror = value;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (sighting_q.size() != 0 || start || visibility_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // driver: one transfer per accepted item, random gap before the next
  always @(posedge clk) begin : drive_items
    bit took;
    int gap_cnt;
    bit no_gaps;
    if (rst) begin
      start   <= 1'b0;
      gap_cnt = 0;
      no_gaps = 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        visibility_q.push_back(predict_visibility(item, cos_mirror, range_mirror));
        if ($urandom_range(0, 99) == 0) no_gaps = !no_gaps;
        gap_cnt = no_gaps ? 0 : $urandom_range(0, 19);
      end
      if (!start || took) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          start <= 1'b0;
        end else if (sighting_q.size() > 0) begin
          item  <= sighting_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_results
    vct_result_t want;
    if (!rst && done) begin
      if (visibility_q.size() == 0) begin
        $error("result transfer with no item outstanding: %b", result);
        mismatch_count++;
      end else begin
        want = visibility_q.pop_front();
        if (result.in_view !== want.in_view) begin
          $error("in_view: expected %b, got %b", want.in_view, result.in_view);
          mismatch_count++;
        end
        if (result.within_angle !== want.within_angle) begin
          $error("within_angle: expected %b, got %b", want.within_angle, result.within_angle);
          mismatch_count++;
        end
        if (result.within_range !== want.within_range) begin
          $error("within_range: expected %b, got %b", want.within_range, result.within_range);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] cos_tab[NUM_PHASES];
    logic [15:0] dist_tab[NUM_PHASES];
    longint      reach;
    cos_tab  = '{16'd23170, 16'd0, 16'h8000, 16'd32767, 16'h8001, 16'd16384, 16'd0};
    dist_tab = '{16'd1000, 16'd65535, 16'd0, 16'd1, 16'd5000, 16'd300, 16'd0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        if (ph == NUM_PHASES - 1) begin
          cos_tab[ph]  = 16'($urandom);
          dist_tab[ph] = 16'($urandom);
        end
        wait_drained();
        write_register(REG_COS_HALF_ANGLE, cos_tab[ph]);
        write_register(REG_MAX_DISTANCE, dist_tab[ph]);
        repeat (2) @(posedge clk);
      end else begin
        // coordinate extremes, facing extremes, ties and perpendiculars
        sighting_q.push_back(place(-32768, -32768, -32768, 32767, 32767, 32767,
                                   32767, 32767, 32767));
        sighting_q.push_back(place(32767, 32767, 32767, -32768, -32768, -32768,
                                   -32768, -32768, -32768));
        sighting_q.push_back(place(-32768, 32767, 0, 32767, -32768, 1, 32767, -32768, -1));
        sighting_q.push_back(place(10, 20, 30, 0, 0, 0, 15, 20, 30));
        sighting_q.push_back(place(0, 0, 0, 32767, 0, 0, 1000, 0, 0));
        sighting_q.push_back(place(0, 0, 0, 32767, 0, 0, 999, 0, 0));
        sighting_q.push_back(place(0, 0, 0, 23170, 0, 0, 5, 0, 0));
        sighting_q.push_back(place(0, 0, 0, 23171, 0, 0, 5, 0, 0));
        sighting_q.push_back(place(0, 0, 0, -32768, 0, 0, 10, 0, 0));
        sighting_q.push_back(place(0, 0, 0, 0, 32767, 0, 0, 0, 7));
        sighting_q.push_back(place(-50, -50, 0, 23170, 23170, 0, 50, 50, 0));
        sighting_q.push_back(place(1, 1, 1, -32768, -32768, -32768, 0, 0, 0));
        sighting_q.push_back(place(-1, 0, 0, 0, 0, -32768, -1, 0, -600));
      end
      push_edge_cases();
      reach = longint'(dist_tab[ph]) * 3 / 2 + 8;
      if (reach > 30000) reach = 30000;
      repeat (RANDOM_PER_PHASE) sighting_q.push_back(random_item(reach));
    end
    wait_drained();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
